// ===== rtl/kvc_pkg.sv =====
// ----------------------------------------------------------------------------
// kvc_pkg
// Shared types and constants for the key/value cache with smallest-key
// eviction: cell commands, cell status flags and fixed field widths.
// ----------------------------------------------------------------------------
package kvc_pkg;

    // fixed field widths of the stream and configuration ports
    localparam int CAP_BITS     = 7;
    localparam int CTR_BITS     = 32;
    localparam int EVICT_BITS   = 7;
    localparam int OUT_VAL_BITS = 32;

    // capacity after reset
    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

    // item kinds carried on s_tuser
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,    // keep contents
        CELL_SHIFT,   // take the upper neighbor's contents
        CELL_INSERT   // open a gap at the sorted position and drop the new pair in
    } cell_op_t;

    // broadcast command from the controller to the chain
    typedef struct packed {
        cell_op_t op;
        logic     wrap;   // top cell takes cell 0 (ring rotate) instead of empty
        logic     upd;    // value carried around from cell 0 is replaced
    } cell_cmd_t;

    // per-cell status toward neighbors and controller
    typedef struct packed {
        logic ins;        // entry is empty or its key is above the new key
        logic match;      // entry is valid and its key equals the new key
    } cell_flags_t;

endpackage

// ===== rtl/keyed_value_cache_min_key_evict_top.sv =====
// ----------------------------------------------------------------------------
// keyed_value_cache_min_key_evict_top
// Bounded key/value cache that evicts the smallest key. Entries sit in a
// chain of cells kept sorted by key, smallest in cell 0, empties on top.
//
//   channel  dir  handshake            content
//   s_       in   s_tvalid/s_tready    tuser: action; tdata: key, value_in
//   m_       out  m_tvalid/m_tready    tuser: found; tdata: value, counts
//   cfg_     in   cfg_valid/cfg_ready  cfg_data: capacity_entries
//
// A lookup or a duplicate insert rotates the chain once around so that
// every entry passes the comparator at cell 0. A new insert rotates the
// same way, then shifts the chain once per eviction and ends with the
// sorted insert.
// Reset empties the chain and clears the counters; capacity returns to 64.
// The result sits in an output register; a stalled m_ side holds only the
// final step of the next transaction.
// ----------------------------------------------------------------------------
module keyed_value_cache_min_key_evict_top #(
    parameter int DEPTH      = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,   // key[63:0], value_in[95:64]
    input  logic [0:0]                    s_tuser,   // action[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,   // value_out[31:0], hit_total[63:32],
                                                     // miss_total[95:64],
                                                     // evicted_count[102:96], zero[103]
    output logic [0:0]                    m_tuser,   // found[0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kvc_pkg::CAP_BITS-1:0]  cfg_data
);
    import kvc_pkg::*;

    cell_cmd_t               cmd;
    logic [KEY_BITS-1:0]     new_key;
    logic [VALUE_BITS-1:0]   new_val;
    logic [KEY_BITS-1:0]     in_key;
    logic [VALUE_BITS-1:0]   in_val;
    logic [63:0]             val_wide;

    logic                    c_valid [DEPTH];
    logic [KEY_BITS-1:0]     c_key   [DEPTH];
    logic [VALUE_BITS-1:0]   c_val   [DEPTH];
    cell_flags_t             c_flags [DEPTH];

    logic                    wrap_valid;
    logic [VALUE_BITS-1:0]   wrap_val;

    logic                    out_found;
    logic [OUT_VAL_BITS-1:0] out_value;
    logic [CTR_BITS-1:0]     out_hits;
    logic [CTR_BITS-1:0]     out_misses;
    logic [EVICT_BITS-1:0]   out_evicted;

    // field extraction, trimmed to the stored widths
    assign in_key   = s_tdata[KEY_BITS-1:0];
    assign val_wide = {32'd0, s_tdata[95:64]};
    assign in_val   = val_wide[VALUE_BITS-1:0];

    kvc_ctrl #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_action   (s_tuser[0]),
        .in_key      (in_key),
        .in_val      (in_val),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .new_key     (new_key),
        .new_val     (new_val),
        .head_flags  (c_flags[0]),
        .head_val    (c_val[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_found   (out_found),
        .out_value   (out_value),
        .out_hits    (out_hits),
        .out_misses  (out_misses),
        .out_evicted (out_evicted)
    );

    // ring closure: cell 0 feeds the top cell on rotate, empty on eviction
    assign wrap_valid = cmd.wrap && c_valid[0];
    assign wrap_val   = cmd.upd ? new_val : c_val[0];

    // sorted chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  up_valid;
        logic [KEY_BITS-1:0]   up_key;
        logic [VALUE_BITS-1:0] up_val;
        logic                  lo_valid;
        logic [KEY_BITS-1:0]   lo_key;
        logic [VALUE_BITS-1:0] lo_val;
        cell_flags_t           lo_flags;

        if (i == DEPTH - 1) begin : g_top
            assign up_valid = wrap_valid;
            assign up_key   = c_key[0];
            assign up_val   = wrap_val;
        end else begin : g_mid
            assign up_valid = c_valid[i+1];
            assign up_key   = c_key[i+1];
            assign up_val   = c_val[i+1];
        end

        if (i == 0) begin : g_head
            // nothing below the head: an insert that reaches it lands here
            assign lo_valid       = 1'b1;
            assign lo_key         = new_key;
            assign lo_val         = new_val;
            assign lo_flags.ins   = 1'b0;
            assign lo_flags.match = 1'b0;
        end else begin : g_body
            assign lo_valid = c_valid[i-1];
            assign lo_key   = c_key[i-1];
            assign lo_val   = c_val[i-1];
            assign lo_flags = c_flags[i-1];
        end

        kvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .new_key  (new_key),
            .new_val  (new_val),
            .up_valid (up_valid),
            .up_key   (up_key),
            .up_val   (up_val),
            .lo_valid (lo_valid),
            .lo_key   (lo_key),
            .lo_val   (lo_val),
            .lo_flags (lo_flags),
            .valid    (c_valid[i]),
            .key      (c_key[i]),
            .val      (c_val[i]),
            .flags    (c_flags[i])
        );
    end

    // result packing
    assign m_tdata = {1'b0, out_evicted, out_misses, out_hits, out_value};
    assign m_tuser = out_found;

endmodule

// ===== rtl/kvc_cell.sv =====
// ----------------------------------------------------------------------------
// kvc_cell
// One cell of the sorted key chain: holds a valid bit, a key and a value,
// compares its key with the pending key and moves data to or from its
// neighbors on shift and insert commands.
// ----------------------------------------------------------------------------
module kvc_cell #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kvc_pkg::cell_cmd_t    cmd,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] new_val,
    // upper neighbor (source on shift)
    input  logic                  up_valid,
    input  logic [KEY_BITS-1:0]   up_key,
    input  logic [VALUE_BITS-1:0] up_val,
    // lower neighbor (source on insert)
    input  logic                  lo_valid,
    input  logic [KEY_BITS-1:0]   lo_key,
    input  logic [VALUE_BITS-1:0] lo_val,
    input  kvc_pkg::cell_flags_t  lo_flags,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] val,
    output kvc_pkg::cell_flags_t  flags
);
    import kvc_pkg::*;

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    // compare against the pending key
    always_comb begin
        flags.ins   = !valid_reg || (key_reg > new_key);
        flags.match = valid_reg && (key_reg == new_key);
    end

    // next contents
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        unique case (cmd.op)
            CELL_HOLD: begin
            end
            CELL_SHIFT: begin
                valid_next = up_valid;
                key_next   = up_key;
                val_next   = up_val;
            end
            CELL_INSERT: begin
                if (flags.ins) begin
                    if (lo_flags.ins) begin
                        valid_next = lo_valid;
                        key_next   = lo_key;
                        val_next   = lo_val;
                    end else begin
                        valid_next = 1'b1;
                        key_next   = new_key;
                        val_next   = new_val;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign val   = val_reg;

endmodule

// ===== rtl/kvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvc_ctrl
// Sequencer for the cell chain: takes one transaction, rotates the chain
// once around to search for the key at cell 0, then for a new insert evicts
// and inserts, and drives the registered result and the hit/miss counters.
// ----------------------------------------------------------------------------
module kvc_ctrl #(
    parameter int DEPTH      = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input transaction
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              in_action,
    input  logic [KEY_BITS-1:0]               in_key,
    input  logic [VALUE_BITS-1:0]             in_val,
    // capacity register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kvc_pkg::CAP_BITS-1:0]      cfg_data,
    // chain
    output kvc_pkg::cell_cmd_t                cmd,
    output logic [KEY_BITS-1:0]               new_key,
    output logic [VALUE_BITS-1:0]             new_val,
    input  kvc_pkg::cell_flags_t              head_flags,
    input  logic [VALUE_BITS-1:0]             head_val,
    // result
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              out_found,
    output logic [kvc_pkg::OUT_VAL_BITS-1:0]  out_value,
    output logic [kvc_pkg::CTR_BITS-1:0]      out_hits,
    output logic [kvc_pkg::CTR_BITS-1:0]      out_misses,
    output logic [kvc_pkg::EVICT_BITS-1:0]    out_evicted
);
    import kvc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_BITS) ? CW : CAP_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CAP_BITS-1:0]     cap_reg, cap_next;
    logic                    hit_reg, hit_next;
    logic [EVICT_BITS-1:0]   ev_reg, ev_next;
    logic [CTR_BITS-1:0]     hits_reg, hits_next;
    logic [CTR_BITS-1:0]     misses_reg, misses_next;
    logic                    act_reg, act_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [VALUE_BITS-1:0]   hval_reg, hval_next;
    logic                    mvalid_reg, mvalid_next;
    logic                    found_reg, found_next;
    logic [OUT_VAL_BITS-1:0] oval_reg, oval_next;
    logic [EVICT_BITS-1:0]   oev_reg, oev_next;

    logic [EW-1:0]           cap_ext, eff_cap;
    logic                    must_evict;
    logic [63:0]             hval_ext;

    // effective capacity: zero acts as one, clipped to the chain length
    always_comb begin
        cap_ext = EW'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > EW'(DEPTH)) begin
            eff_cap = EW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
        must_evict = (EW'(count_reg) >= eff_cap) && (count_reg != '0);
    end

    assign hval_ext = 64'(hval_reg);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        cap_next    = cap_reg;
        hit_next    = hit_reg;
        ev_next     = ev_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        hval_next   = hval_reg;
        mvalid_next = mvalid_reg;
        found_next  = found_reg;
        oval_next   = oval_reg;
        oev_next    = oev_reg;
        cmd.op      = CELL_HOLD;
        cmd.wrap    = 1'b0;
        cmd.upd     = 1'b0;
        s_tready    = (state_reg == ST_IDLE);
        cfg_ready   = 1'b1;

        if (cfg_valid) begin
            cap_next = cfg_data;
        end

        // output slot drains independently
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = in_action;
                    key_next   = in_key;
                    val_next   = in_val;
                    pos_next   = '0;
                    hit_next   = 1'b0;
                    ev_next    = '0;
                    state_next = ST_SCAN;
                end
            end
            // one full ring rotation; every entry passes cell 0 once
            ST_SCAN: begin
                cmd.op   = CELL_SHIFT;
                cmd.wrap = 1'b1;
                if (head_flags.match) begin
                    hit_next  = 1'b1;
                    hval_next = head_val;
                    cmd.upd   = (act_reg == ACT_INSERT);
                end
                pos_next = pos_reg + AW'(1);
                if (pos_reg == AW'(DEPTH - 1)) begin
                    if (act_reg == ACT_LOOKUP || hit_next) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_EVICT;
                    end
                end
            end
            // drop smallest keys one a cycle, then insert in sorted place
            ST_EVICT: begin
                if (must_evict) begin
                    cmd.op     = CELL_SHIFT;
                    count_next = count_reg - CW'(1);
                    ev_next    = ev_reg + EVICT_BITS'(1);
                end else begin
                    cmd.op     = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    if (act_reg == ACT_LOOKUP) begin
                        found_next = hit_reg;
                        oval_next  = hit_reg ? hval_ext[OUT_VAL_BITS-1:0] : '0;
                        if (hit_reg) begin
                            hits_next = hits_reg + CTR_BITS'(1);
                        end else begin
                            misses_next = misses_reg + CTR_BITS'(1);
                        end
                    end else begin
                        found_next = 1'b0;
                        oval_next  = '0;
                    end
                    oev_next   = ev_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            count_reg  <= '0;
            cap_reg    <= CAP_RESET;
            hit_reg    <= 1'b0;
            ev_reg     <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            cap_reg    <= cap_next;
            hit_reg    <= hit_next;
            ev_reg     <= ev_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // transaction and result payload
    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        hval_reg  <= hval_next;
        found_reg <= found_next;
        oval_reg  <= oval_next;
        oev_reg   <= oev_next;
    end

    assign new_key     = key_reg;
    assign new_val     = val_reg;
    assign m_tvalid    = mvalid_reg;
    assign out_found   = found_reg;
    assign out_value   = oval_reg;
    assign out_hits    = hits_reg;
    assign out_misses  = misses_reg;
    assign out_evicted = oev_reg;

endmodule
